### rtl/mfs_pkg.sv
// Shared constants and types for the max-frequency stack.
// No dependencies; used by max_frequency_stack_core, mfs_checker and the testbench files mfs_tb_pkg and tb.
`default_nettype none

package mfs_pkg;

  // fixed field widths of the item and result words
  localparam int unsigned VALUE_W  = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEVEL_W  = 9;

  // value range covered by the count table
  localparam int unsigned VALUE_SPACE = 1024;

  // default pool size
  localparam int unsigned ENTRIES_DEFAULT = 256;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,   // count table sweep after reset
    S_IDLE,    // waiting for an input word
    S_P_RD,    // push: count and free link back, read level head
    S_P_WR,    // push: link entry, write level head
    S_Q_RD1,   // pop: level head back, read entry
    S_Q_RD2,   // pop: entry back, read count, unlink, free entry
    S_Q_WR,    // pop: count back, write decremented count
    S_DONE     // result ready, hand to output register
  } state_e;

endpackage

`default_nettype wire

### rtl/max_frequency_stack_core.sv
// Max-frequency stack core: count table and level heads share one RAM, entry
// pool in a second RAM. Depends on mfs_pkg.
`default_nettype none

// Usage
// -----
// Input channel (in_valid_i / in_ready_o) takes one word: operation_i selects
// push (value_i) or pop. Output channel (out_valid_o / out_ready_i) returns one
// word per input word: popped_value_o, status_o (ok / pop on empty / push into
// a full pool) and top_level_o, the highest non-empty level after the word.
// One input word is worked on at a time; the sequencer walks dependent reads
// of the count/level-head RAM and the entry RAM, whose reads are registered.
// Steps: a push runs S_P_RD, S_P_WR, S_DONE; a pop runs S_Q_RD1, S_Q_RD2,
// S_Q_WR, S_DONE; a rejected push or a pop on empty goes straight to S_DONE.
// out_valid_o rises once S_DONE hands the result to the output register. The
// next input is taken only back in S_IDLE, after that hand-over.
// Reset: control state clears at once, then the count table is swept to zero,
// one entry a cycle over all VALUE_SPACE (1024) entries, with in_ready_o low.
// Output stall: the result sits in the output register; the sequencer may
// accept and finish one more word, then waits in its final step until the
// output register frees up. No word is dropped or repeated.

module max_frequency_stack_core #(
  parameter int unsigned ENTRIES = mfs_pkg::ENTRIES_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [mfs_pkg::VALUE_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [mfs_pkg::VALUE_W-1:0]       popped_value_o,
  output logic [mfs_pkg::STATUS_W-1:0]      status_o,
  output logic [mfs_pkg::LEVEL_W-1:0]       top_level_o
);

  localparam int unsigned ValW   = mfs_pkg::VALUE_W;
  localparam int unsigned LevelW = mfs_pkg::LEVEL_W;
  localparam int unsigned IdxW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW   = $clog2(ENTRIES + 1);
  // entry word: {value, last, link}
  localparam int unsigned EntW   = ValW + 1 + IdxW;
  // shared table: counts at 0..VALUE_SPACE-1, head of level f at HeadBase+f-1
  localparam int unsigned TabD   = mfs_pkg::VALUE_SPACE + ENTRIES;
  localparam int unsigned TabAW  = $clog2(TabD);

  localparam logic [CntW-1:0]  EntriesC = CntW'(ENTRIES);
  localparam logic [ValW-1:0]  ClrLast  = ValW'(mfs_pkg::VALUE_SPACE - 1);
  localparam logic [TabAW-1:0] HeadBase = TabAW'(mfs_pkg::VALUE_SPACE);

  // ---------------------------------------------------------------------------
  // RAMs
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] tab_mem [TabD];
  logic [EntW-1:0] ent_mem [ENTRIES];

  logic            cnt_re, cnt_we;
  logic [ValW-1:0] cnt_raddr, cnt_waddr;
  logic [CntW-1:0] cnt_wdata, cnt_rd_q;

  logic            ent_re, ent_we;
  logic [IdxW-1:0] ent_raddr, ent_waddr;
  logic [EntW-1:0] ent_wdata, ent_rd_q;

  logic            head_re, head_we;
  logic [IdxW-1:0] head_raddr, head_waddr;
  logic [IdxW-1:0] head_wdata, head_rd_q;

  logic             tab_re, tab_we;
  logic [TabAW-1:0] tab_raddr, tab_waddr;
  logic [CntW-1:0]  tab_wdata, tab_rd_q;

  // count and head accesses never need the same port in one cycle
  assign tab_re    = cnt_re || head_re;
  assign tab_we    = cnt_we || head_we;
  assign tab_raddr = head_re ? HeadBase + TabAW'(head_raddr) : TabAW'(cnt_raddr);
  assign tab_waddr = head_we ? HeadBase + TabAW'(head_waddr) : TabAW'(cnt_waddr);
  assign tab_wdata = head_we ? CntW'(head_wdata) : cnt_wdata;
  assign cnt_rd_q  = tab_rd_q;
  assign head_rd_q = tab_rd_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rd_q <= tab_mem[tab_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  // entry read fields
  logic [ValW-1:0] ent_value;
  logic            ent_last;
  logic [IdxW-1:0] ent_link;
  assign {ent_value, ent_last, ent_link} = ent_rd_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  mfs_pkg::state_e  state_q, state_d;
  logic [ValW-1:0]  clr_q, clr_d;
  logic [ValW-1:0]  val_q, val_d;          // value being pushed / popped
  logic [IdxW-1:0]  slot_q, slot_d;        // pool entry in use by this word
  logic [CntW-1:0]  flvl_q, flvl_d;        // new count = target level on push
  logic [CntW-1:0]  hl_q, hl_d;            // highest non-empty level
  logic [CntW-1:0]  live_q, live_d;
  logic [CntW-1:0]  fresh_q, fresh_d;
  logic [IdxW-1:0]  fhead_q, fhead_d;      // free list head
  logic             fvalid_q, fvalid_d;
  logic [ValW-1:0]  res_val_q, res_val_d;
  mfs_pkg::status_e res_st_q, res_st_d;

  logic               out_valid_q, out_valid_d;
  logic [ValW-1:0]    out_val_q, out_val_d;
  mfs_pkg::status_e   out_st_q, out_st_d;
  logic [LevelW-1:0]  out_lvl_q, out_lvl_d;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // push helpers
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] push_lvl;
  assign cnt_inc  = cnt_rd_q + 1'b1;
  assign push_lvl = (cnt_rd_q >= EntriesC) ? EntriesC : cnt_inc;

  logic [CntW-1:0] hl_dec;
  assign hl_dec = hl_q - 1'b1;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin : p_next
    state_d = state_q;
    case (state_q)
      mfs_pkg::S_CLEAR: begin
        if (clr_q == ClrLast) begin
          state_d = mfs_pkg::S_IDLE;
        end
      end
      mfs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == mfs_pkg::OP_PUSH) begin
            state_d = (live_q >= EntriesC) ? mfs_pkg::S_DONE : mfs_pkg::S_P_RD;
          end else begin
            state_d = (hl_q == '0) ? mfs_pkg::S_DONE : mfs_pkg::S_Q_RD1;
          end
        end
      end
      mfs_pkg::S_P_RD:  state_d = mfs_pkg::S_P_WR;
      mfs_pkg::S_P_WR:  state_d = mfs_pkg::S_DONE;
      mfs_pkg::S_Q_RD1: state_d = mfs_pkg::S_Q_RD2;
      mfs_pkg::S_Q_RD2: state_d = mfs_pkg::S_Q_WR;
      mfs_pkg::S_Q_WR:  state_d = mfs_pkg::S_DONE;
      mfs_pkg::S_DONE: begin
        if (out_free) begin
          state_d = mfs_pkg::S_IDLE;
        end
      end
      default: state_d = mfs_pkg::S_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // RAM control and datapath
  // ---------------------------------------------------------------------------
  always_comb begin : p_out
    cnt_re     = 1'b0;
    cnt_we     = 1'b0;
    cnt_raddr  = val_q;
    cnt_waddr  = val_q;
    cnt_wdata  = '0;
    ent_re     = 1'b0;
    ent_we     = 1'b0;
    ent_raddr  = fhead_q;
    ent_waddr  = slot_q;
    ent_wdata  = '0;
    head_re    = 1'b0;
    head_we    = 1'b0;
    head_raddr = IdxW'(hl_dec);
    head_waddr = IdxW'(hl_dec);
    head_wdata = slot_q;

    clr_d     = clr_q;
    val_d     = val_q;
    slot_d    = slot_q;
    flvl_d    = flvl_q;
    hl_d      = hl_q;
    live_d    = live_q;
    fresh_d   = fresh_q;
    fhead_d   = fhead_q;
    fvalid_d  = fvalid_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;

    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    out_lvl_d   = out_lvl_q;

    in_ready_o = 1'b0;

    case (state_q)
      mfs_pkg::S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end

      mfs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          val_d     = value_i;
          res_val_d = '0;
          res_st_d  = mfs_pkg::ST_OK;
          if (operation_i == mfs_pkg::OP_PUSH) begin
            if (live_q >= EntriesC) begin
              res_st_d = mfs_pkg::ST_FULL;
            end else begin
              cnt_re    = 1'b1;
              cnt_raddr = value_i;
              // link of the free head, used only if the free list is valid
              ent_re    = 1'b1;
              ent_raddr = fhead_q;
            end
          end else begin
            if (hl_q == '0) begin
              res_st_d = mfs_pkg::ST_EMPTY;
            end else begin
              head_re    = 1'b1;
              head_raddr = IdxW'(hl_dec);
            end
          end
        end
      end

      mfs_pkg::S_P_RD: begin
        flvl_d     = push_lvl;
        cnt_we     = 1'b1;
        cnt_waddr  = val_q;
        cnt_wdata  = push_lvl;
        head_re    = 1'b1;
        head_raddr = IdxW'(push_lvl - 1'b1);
        if (fvalid_q) begin
          slot_d = fhead_q;
          if (ent_last) begin
            fhead_d  = '0;
            fvalid_d = 1'b0;
          end else begin
            fhead_d = ent_link;
          end
        end else begin
          slot_d  = fresh_q[IdxW-1:0];
          fresh_d = fresh_q + 1'b1;
        end
      end

      mfs_pkg::S_P_WR: begin
        ent_we    = 1'b1;
        ent_waddr = slot_q;
        if (flvl_q <= hl_q) begin
          ent_wdata = {val_q, 1'b0, head_rd_q};
        end else begin
          ent_wdata = {val_q, 1'b1, {IdxW{1'b0}}};
        end
        head_we    = 1'b1;
        head_waddr = IdxW'(flvl_q - 1'b1);
        head_wdata = slot_q;
        if (flvl_q > hl_q) begin
          hl_d = flvl_q;
        end
        live_d = live_q + 1'b1;
      end

      mfs_pkg::S_Q_RD1: begin
        slot_d    = head_rd_q;
        ent_re    = 1'b1;
        ent_raddr = head_rd_q;
      end

      mfs_pkg::S_Q_RD2: begin
        val_d     = ent_value;
        res_val_d = ent_value;
        cnt_re    = 1'b1;
        cnt_raddr = ent_value;
        if (ent_last) begin
          hl_d = hl_dec;
        end else begin
          head_we    = 1'b1;
          head_waddr = IdxW'(hl_dec);
          head_wdata = ent_link;
        end
        // freed entry goes on top of the free list
        ent_we    = 1'b1;
        ent_waddr = slot_q;
        if (fvalid_q) begin
          ent_wdata = {ent_value, 1'b0, fhead_q};
        end else begin
          ent_wdata = {ent_value, 1'b1, {IdxW{1'b0}}};
        end
        fhead_d  = slot_q;
        fvalid_d = 1'b1;
        if (live_q != '0) begin
          live_d = live_q - 1'b1;
        end
      end

      mfs_pkg::S_Q_WR: begin
        if (cnt_rd_q != '0) begin
          cnt_we    = 1'b1;
          cnt_waddr = val_q;
          cnt_wdata = cnt_rd_q - 1'b1;
        end
      end

      mfs_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          out_lvl_d   = LevelW'(hl_q);
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfs_pkg::S_CLEAR;
      clr_q       <= '0;
      hl_q        <= '0;
      live_q      <= '0;
      fresh_q     <= '0;
      fhead_q     <= '0;
      fvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hl_q        <= hl_d;
      live_q      <= live_d;
      fresh_q     <= fresh_d;
      fhead_q     <= fhead_d;
      fvalid_q    <= fvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    slot_q    <= slot_d;
    flvl_q    <= flvl_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
    out_lvl_q <= out_lvl_d;
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_val_q;
  assign status_o       = out_st_q;
  assign top_level_o    = out_lvl_q;

endmodule

`default_nettype wire

### rtl/mfs_checker.sv
// Port-level checks for max_frequency_stack_core, bound into that module.
// Depends on mfs_pkg.
`default_nettype none

module mfs_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         operation_i,
  input wire logic [mfs_pkg::VALUE_W-1:0]  value_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [mfs_pkg::VALUE_W-1:0]  popped_value_o,
  input wire logic [mfs_pkg::STATUS_W-1:0] status_o,
  input wire logic [mfs_pkg::LEVEL_W-1:0]  top_level_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(popped_value_o)
      && $stable(status_o) && $stable(top_level_o))
    else $error("output word changed while stalled");

  // one word in flight: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // pop on empty reports an empty stack
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mfs_pkg::ST_EMPTY |->
      top_level_o == '0 && popped_value_o == '0)
    else $error("empty status with nonzero fields");

  // rejected push returns no value and a non-empty stack
  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mfs_pkg::ST_FULL |->
      popped_value_o == '0 && top_level_o != '0)
    else $error("full status with bad fields");

endmodule

bind max_frequency_stack_core mfs_checker u_mfs_checker (.*);

`default_nettype wire

### verif/mfs_tb_pkg.sv
`timescale 1ns / 1ps
// Frequency-stack tracker for the max_frequency_stack_core testbench: keeps its
// own count table, entry pool and level lists, and queues the result of each word.
// Depends on mfs_pkg.

package mfs_tb_pkg;

  import mfs_pkg::*;

  localparam int unsigned POOL      = ENTRIES_DEFAULT;
  localparam int unsigned SLOT_W    = $clog2(POOL);
  localparam int unsigned LIST_END  = POOL;  // link value that ends a list
  localparam int unsigned SHOWN_MAX = 50;    // mismatch lines printed, rest only counted

  typedef struct {
    logic [VALUE_W-1:0] popped;
    status_e            status;
    logic [LEVEL_W-1:0] level;
  } stack_result_t;

  class freq_stack_board;

    logic [LEVEL_W-1:0] occurrences [VALUE_SPACE];
    logic [VALUE_W-1:0] entry_val   [POOL];
    logic [LEVEL_W-1:0] entry_next  [POOL];
    logic [SLOT_W-1:0]  level_head  [POOL];  // level f kept at index f-1
    logic [LEVEL_W-1:0] top_level;
    int unsigned        in_use;
    int unsigned        never_used;
    int unsigned        free_top;
    bit                 free_ok;

    stack_result_t      results_due [$];
    int unsigned        results_seen;
    int unsigned        errors;

    function new();
      foreach (occurrences[i]) occurrences[i] = '0;
      foreach (entry_val[i]) begin
        entry_val[i]  = '0;
        entry_next[i] = '0;
        level_head[i] = '0;
      end
      top_level    = '0;
      in_use       = 0;
      never_used   = 0;
      free_top     = 0;
      free_ok      = 1'b0;
      results_seen = 0;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // Apply one accepted word to the tracked stack and queue its result.
    function void note_word(op_e op, logic [VALUE_W-1:0] val);
      stack_result_t r;
      int unsigned   slot;
      int unsigned   f;
      int unsigned   v;
      int unsigned   nxt;
      int unsigned   lvl;
      r.popped = '0;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
        if (in_use >= POOL) begin
          r.status = ST_FULL;
        end else begin
          v = val % VALUE_SPACE;
          // free list first, then entries never handed out
          if (free_ok) begin
            slot = free_top;
            if (entry_next[slot] < LIST_END) free_top = entry_next[slot];
            else begin
              free_top = 0;
              free_ok  = 1'b0;
            end
          end else begin
            slot = never_used % POOL;
            never_used++;
          end
          f = occurrences[v] + 1;
          if (f > POOL) f = POOL;
          occurrences[v]  = LEVEL_W'(f);
          entry_val[slot] = VALUE_W'(v);
          entry_next[slot] = (f <= top_level) ? LEVEL_W'(level_head[f-1])
                                              : LEVEL_W'(LIST_END);
          level_head[f-1] = SLOT_W'(slot);
          if (f > top_level) top_level = LEVEL_W'(f);
          in_use++;
        end
      end else begin
        if (top_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lvl  = top_level - 1;
          slot = level_head[lvl];
          v    = entry_val[slot];
          nxt  = entry_next[slot];
          r.popped = VALUE_W'(v);
          if (occurrences[v] != 0) occurrences[v]--;
          if (nxt < LIST_END) level_head[lvl] = SLOT_W'(nxt);
          else top_level--;
          entry_next[slot] = free_ok ? LEVEL_W'(free_top) : LEVEL_W'(LIST_END);
          free_top = slot;
          free_ok  = 1'b1;
          if (in_use > 0) in_use--;
        end
      end
      r.level = top_level;
      results_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= SHOWN_MAX) $display("%0t MISMATCH %s", $time, msg);
    endtask

    task check_result(logic [VALUE_W-1:0] popped, logic [STATUS_W-1:0] status,
                      logic [LEVEL_W-1:0] level);
      stack_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result with no word outstanding: popped %0d status %0d level %0d",
                         popped, status, level));
        return;
      end
      want = results_due.pop_front();
      if (popped !== want.popped)
        report($sformatf("result %0d: popped_value %0d, expected %0d",
                         results_seen, popped, want.popped));
      if (status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d",
                         results_seen, status, want.status));
      if (level !== want.level)
        report($sformatf("result %0d: top_level %0d, expected %0d",
                         results_seen, level, want.level));
      results_seen++;
    endtask

  endclass

endpackage

### verif/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for max_frequency_stack_core: directed and random push/pop
// words with random stalls on both channels, checked by the frequency-stack tracker.
// Depends on mfs_pkg, mfs_tb_pkg and the core RTL.

module tb;

  import mfs_pkg::*;
  import mfs_tb_pkg::*;

  localparam int unsigned WORD_TARGET   = 1550;
  localparam int unsigned SETTLE_CYCLES = 20;   // well past the pop latency
  localparam int unsigned HOLD_CYCLES   = 400;  // long receiver hold-off

  // shapes of a random stretch of words
  typedef enum int unsigned {
    MIX_WIDE,    // push/pop mix over the whole value range
    MIX_HOT,     // mix biased to a few values, builds deep levels
    FILL_POOL,   // push until the pool is full, then a few rejected pushes
    DRAIN_POOL,  // pop until empty, then a few pops on empty
    SOLO_FILL    // one value pushed until full: level climbs to the pool size
  } shape_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               operation_i;
  logic [VALUE_W-1:0]  value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [VALUE_W-1:0]  popped_value_o;
  logic [STATUS_W-1:0] status_o;
  logic [LEVEL_W-1:0]  top_level_o;

  freq_stack_board board = new();

  int unsigned words_sent   = 0;
  int unsigned tx_idle_pct  = 15;
  int unsigned rx_idle_pct  = 15;
  int unsigned rx_hold_left = 0;

  max_frequency_stack_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .top_level_o    (top_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run (reset sweep, hold-off, all stalls).
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: ready changes on the falling edge. A pending hold-off wins over the
  // random stalls and is counted down here, once per falling edge.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Output monitor: a word moves when valid and ready are both high at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(popped_value_o, status_o, top_level_o);
  end

  // Offer one word; called on a falling edge, returns on a falling edge after the
  // word is taken. Random idle cycles come first, with junk on the payload while
  // valid is low. Valid is never dropped between back-to-back words.
  task automatic send_word(op_e op, logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i  <= 1'b0;
      operation_i <= 1'($urandom_range(1));
      value_i     <= VALUE_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_word(op, val);
    words_sent++;
    @(negedge clk_i);
  endtask

  // The value field rides along on a pop and must be ignored.
  task automatic pop_word();
    send_word(OP_POP, VALUE_W'($urandom));
  endtask

  // Sender goes quiet until every outstanding result is back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.pending() != 0);
  endtask

  initial begin
    shape_e             shape;
    int unsigned        phase;
    int unsigned        span;
    int unsigned        push_pct;
    logic [VALUE_W-1:0] solo;
    logic [VALUE_W-1:0] hot [3];

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_PUSH;
    value_i     = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // in_ready_o stays low through the count-table sweep; send_word just waits

    // Directed: pop on empty, value extremes and alternating bit patterns, a value
    // climbing to levels 2 and 3, then pop everything and pop on empty again.
    pop_word();
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, 10'h3FF);
    send_word(OP_PUSH, 10'h155);
    send_word(OP_PUSH, 10'h2AA);
    send_word(OP_PUSH, 10'h3FF);
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, '0);
    repeat (8) pop_word();
    pop_word();

    // Random stretches until the word budget is spent.
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      phase++;
      // phases 6..9 run with no idling on either side
      tx_idle_pct = (phase >= 6 && phase <= 9) ? 0 : 15;
      rx_idle_pct = tx_idle_pct;
      // long receiver hold-off: sender keeps offering, core backs up into input
      if (phase == 3) rx_hold_left = HOLD_CYCLES;

      if (phase == 1) shape = SOLO_FILL;       // stack is empty right after directed
      else if (phase == 3) shape = MIX_WIDE;
      else begin
        case ($urandom_range(9))
          0, 1, 2, 3: shape = MIX_WIDE;
          4, 5:       shape = MIX_HOT;
          6, 7:       shape = FILL_POOL;
          default:    shape = DRAIN_POOL;
        endcase
      end
      foreach (hot[i]) hot[i] = VALUE_W'($urandom);

      case (shape)
        SOLO_FILL: begin
          // one value to level POOL, then rejected pushes, then full drain
          solo = VALUE_W'($urandom);
          repeat (POOL + 2) send_word(OP_PUSH, solo);
          while (board.top_level != 0) pop_word();
          repeat (2) pop_word();
        end
        MIX_WIDE, MIX_HOT: begin
          span     = $urandom_range(20, 100);
          push_pct = $urandom_range(35, 70);
          repeat (span) begin
            if ($urandom_range(99) >= push_pct) pop_word();
            else if (shape == MIX_HOT && $urandom_range(9) < 8)
              send_word(OP_PUSH, hot[$urandom_range(2)]);
            else send_word(OP_PUSH, VALUE_W'($urandom));
          end
        end
        FILL_POOL: begin
          while (board.in_use < POOL && words_sent < WORD_TARGET) begin
            if ($urandom_range(1) == 1) send_word(OP_PUSH, hot[$urandom_range(2)]);
            else send_word(OP_PUSH, VALUE_W'($urandom));
          end
          repeat ($urandom_range(1, 3)) send_word(OP_PUSH, VALUE_W'($urandom));
        end
        default: begin
          while (board.top_level != 0 && words_sent < WORD_TARGET) pop_word();
          repeat ($urandom_range(1, 2)) pop_word();
        end
      endcase

      // sender pause until the core has handed back everything
      if (phase == 4 || $urandom_range(4) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/mfs_pkg.sv
rtl/max_frequency_stack_core.sv
rtl/mfs_checker.sv
verif/mfs_tb_pkg.sv
verif/tb.sv
